// ===== rtl/core/sarc_pkg.sv =====
// ----------------------------------------------------------------------------
// sarc_pkg
// Shared types and codes of the slot allocator with row compaction.
// ----------------------------------------------------------------------------
package sarc_pkg;

    localparam int MAX_SLOTS = 64;
    localparam int SLOT_W    = 6;
    localparam int CNT_W     = 7;

    // command codes
    localparam logic [2:0] CMD_RESET_ALL = 3'd0;
    localparam logic [2:0] CMD_RESERVE   = 3'd1;
    localparam logic [2:0] CMD_RELEASE   = 3'd2;
    localparam logic [2:0] CMD_COMPACT   = 3'd3;
    localparam logic [2:0] CMD_READ_ROW  = 3'd4;

    // status codes
    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_NONE_FREE = 4'd1;
    localparam logic [3:0] ST_SLOT_RNG  = 4'd2;
    localparam logic [3:0] ST_DBL_FREE  = 4'd3;
    localparam logic [3:0] ST_BATCH_RNG = 4'd4;
    localparam logic [3:0] ST_SIZE_MIS  = 4'd5;
    localparam logic [3:0] ST_TGT_RNG   = 4'd6;
    localparam logic [3:0] ST_DUP       = 4'd7;
    localparam logic [3:0] ST_HOLE      = 4'd8;
    localparam logic [3:0] ST_ROW_RNG   = 4'd9;

    // one accepted command, classified
    typedef struct packed {
        logic [2:0]        cmd;
        logic [CNT_W-1:0]  batch_size;
        logic [SLOT_W-1:0] slot;
        logic [6:0]        target_row;
        logic [CNT_W-1:0]  new_batch_size;
        logic              last_row;
        logic [SLOT_W-1:0] row;
        logic              reads_table;
    } t_item;

    // queue handshake between front and back
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_queue_out;

endpackage

// ===== rtl/core/sarc_front.sv =====
// ----------------------------------------------------------------------------
// sarc_front
// Accepts commands, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module sarc_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  sarc_pkg::t_item       i_item,
    output sarc_pkg::t_queue_out  o_queue,
    input  logic                  i_pop
);

    sarc_pkg::t_item r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_push;
    logic       w_pop;
    sarc_pkg::t_item w_cls;

    assign o_ready       = (r_count != 2'd2);
    assign w_push        = i_valid && o_ready;
    assign w_pop         = i_pop && (r_count != 2'd0);
    assign o_queue.valid = (r_count != 2'd0);
    assign o_queue.item  = r_mem[r_rd_ptr];

    // mark commands that need a table lookup
    always_comb begin
        w_cls = i_item;
        w_cls.reads_table = (i_item.cmd == sarc_pkg::CMD_COMPACT) ||
                            (i_item.cmd == sarc_pkg::CMD_READ_ROW);
    end

    // store payload
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_cls;
        end
    end

    // advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) r_wr_ptr <= ~r_wr_ptr;
            if (w_pop)  r_rd_ptr <= ~r_rd_ptr;
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/core/sarc_back.sv =====
// ----------------------------------------------------------------------------
// sarc_back
// Executes commands on the free map and the two-bank row table.
// ----------------------------------------------------------------------------
module sarc_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [6:0]           i_cfg_wdata,
    input  sarc_pkg::t_queue_out i_queue,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [23:0]          o_data
);

    localparam int MS = sarc_pkg::MAX_SLOTS;
    localparam int CW = sarc_pkg::CNT_W;
    localparam int SW = sarc_pkg::SLOT_W;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic            r_state;
    sarc_pkg::t_item r_item;
    logic [CW-1:0]   r_cap;
    logic [MS-1:0]   r_map;
    logic [CW-1:0]   r_free_cnt;
    logic [CW-1:0]   r_active;
    logic            r_bank;
    logic [1:0]      r_ident;
    logic [MS-1:0]   r_filled;
    logic [CW-1:0]   r_idx;
    logic            r_failed;
    logic            r_recount;
    logic [CW-1:0]   r_rc_idx;
    logic [CW-1:0]   r_rc_acc;
    logic [SW-1:0]   r_mem [2*MS];
    logic [SW-1:0]   r_rdata;
    logic            r_out_valid;
    logic [23:0]     r_out_data;

    logic [CW-1:0]   w_ecap;
    logic [MS-1:0]   w_capmask;
    logic [MS-1:0]   w_avail;
    logic            w_any_free;
    logic [SW-1:0]   w_lowest;
    logic            w_out_can;
    logic            w_start;
    logic            w_done;
    logic [SW:0]     w_raddr;

    // results of executing the held item
    logic [3:0]      w_st;
    logic [SW-1:0]   w_slot_out;
    logic [MS-1:0]   w_map_n;
    logic [CW-1:0]   w_free_n;
    logic [CW-1:0]   w_active_n;
    logic            w_bank_n;
    logic [1:0]      w_ident_n;
    logic [MS-1:0]   w_filled_n;
    logic [CW-1:0]   w_idx_n;
    logic            w_failed_n;
    logic            w_wr;
    logic [SW-1:0]   w_src_slot;
    logic [MS-1:0]   w_hole_mask;

    assign w_ecap    = (r_cap > CW'(MS)) ? CW'(MS) : r_cap;
    assign w_out_can = !r_out_valid || i_ready;
    assign w_start   = (r_state == S_IDLE) && i_queue.valid && !r_recount;
    assign w_done    = (r_state == S_EXEC) && w_out_can;
    assign o_pop     = w_start;
    assign o_valid   = r_out_valid;
    assign o_data    = r_out_data;

    // capacity mask and lowest free slot
    always_comb begin
        for (int i = 0; i < MS; i++) begin
            w_capmask[i] = (CW'(i) < w_ecap);
        end
        w_avail    = r_map & w_capmask;
        w_any_free = |w_avail;
        w_lowest   = '0;
        for (int i = MS - 1; i >= 0; i--) begin
            if (w_avail[i]) w_lowest = SW'(i);
        end
    end

    // table read address for the item being started
    always_comb begin
        if (i_queue.item.cmd == sarc_pkg::CMD_COMPACT) begin
            w_raddr = {r_bank, r_idx[SW-1:0]};
        end else begin
            w_raddr = {r_bank, i_queue.item.row};
        end
    end

    // execute the held command
    always_comb begin
        w_st        = sarc_pkg::ST_OK;
        w_slot_out  = '0;
        w_map_n     = r_map;
        w_free_n    = r_free_cnt;
        w_active_n  = r_active;
        w_bank_n    = r_bank;
        w_ident_n   = r_ident;
        w_filled_n  = r_filled;
        w_idx_n     = r_idx;
        w_failed_n  = r_failed;
        w_wr        = 1'b0;
        w_src_slot  = r_ident[r_bank] ? r_idx[SW-1:0] : r_rdata;
        w_hole_mask = '0;
        case (r_item.cmd)
            sarc_pkg::CMD_RESET_ALL: begin
                if (r_item.batch_size > w_ecap) begin
                    w_st = sarc_pkg::ST_BATCH_RNG;
                end else begin
                    for (int i = 0; i < MS; i++) begin
                        w_map_n[i] = w_capmask[i] && (CW'(i) >= r_item.batch_size);
                    end
                    w_free_n           = w_ecap - r_item.batch_size;
                    w_active_n         = r_item.batch_size;
                    w_ident_n[r_bank]  = 1'b1;
                    w_failed_n         = 1'b0;
                    w_idx_n            = '0;
                    w_filled_n         = '0;
                end
            end
            sarc_pkg::CMD_RESERVE: begin
                if (!w_any_free) begin
                    w_st = sarc_pkg::ST_NONE_FREE;
                end else begin
                    w_map_n[w_lowest] = 1'b0;
                    w_free_n          = r_free_cnt - CW'(1);
                    w_slot_out        = w_lowest;
                end
            end
            sarc_pkg::CMD_RELEASE: begin
                if ({1'b0, r_item.slot} >= w_ecap) begin
                    w_st = sarc_pkg::ST_SLOT_RNG;
                end else if (r_map[r_item.slot]) begin
                    w_st = sarc_pkg::ST_DBL_FREE;
                end else begin
                    w_map_n[r_item.slot] = 1'b1;
                    w_free_n             = r_free_cnt + CW'(1);
                end
            end
            sarc_pkg::CMD_COMPACT: begin
                if (r_failed) begin
                    if (r_item.last_row) begin
                        w_failed_n = 1'b0;
                        w_idx_n    = '0;
                        w_filled_n = '0;
                    end
                end else begin
                    if (r_item.new_batch_size > r_active) begin
                        w_st = sarc_pkg::ST_BATCH_RNG;
                    end else if (r_idx >= r_active) begin
                        w_st = sarc_pkg::ST_SIZE_MIS;
                    end else begin
                        if (r_item.target_row[6]) begin
                            if ({1'b0, w_src_slot} >= w_ecap) begin
                                w_st = sarc_pkg::ST_SLOT_RNG;
                            end else if (r_map[w_src_slot]) begin
                                w_st = sarc_pkg::ST_DBL_FREE;
                            end else begin
                                w_map_n[w_src_slot] = 1'b1;
                                w_free_n            = r_free_cnt + CW'(1);
                            end
                        end else if (r_item.target_row >= r_item.new_batch_size) begin
                            w_st = sarc_pkg::ST_TGT_RNG;
                        end else if (r_filled[r_item.target_row[SW-1:0]]) begin
                            w_st = sarc_pkg::ST_DUP;
                        end else begin
                            w_wr                                   = 1'b1;
                            w_filled_n[r_item.target_row[SW-1:0]]  = 1'b1;
                            w_ident_n[~r_bank]                     = 1'b0;
                        end
                        if (w_st == sarc_pkg::ST_OK) w_idx_n = r_idx + CW'(1);
                    end
                    if (w_st == sarc_pkg::ST_OK && r_item.last_row) begin
                        for (int i = 0; i < MS; i++) begin
                            w_hole_mask[i] = (CW'(i) < r_item.new_batch_size);
                        end
                        if (w_idx_n != r_active) begin
                            w_st = sarc_pkg::ST_SIZE_MIS;
                        end else if ((w_hole_mask & ~w_filled_n) != '0) begin
                            w_st = sarc_pkg::ST_HOLE;
                        end
                        if (w_st == sarc_pkg::ST_OK) begin
                            w_bank_n   = ~r_bank;
                            w_active_n = r_item.new_batch_size;
                        end
                        w_idx_n    = '0;
                        w_filled_n = '0;
                    end else if (w_st != sarc_pkg::ST_OK) begin
                        w_idx_n    = '0;
                        w_filled_n = '0;
                        w_failed_n = !r_item.last_row;
                    end
                end
            end
            sarc_pkg::CMD_READ_ROW: begin
                if ({1'b0, r_item.row} >= r_active) begin
                    w_st = sarc_pkg::ST_ROW_RNG;
                end else begin
                    w_slot_out = r_ident[r_bank] ? r_item.row : r_rdata;
                end
            end
            default: begin
                w_st = sarc_pkg::ST_OK;
            end
        endcase
    end

    // row table: one read on start for items that use it, one write on execute when a row is mapped
    always_ff @(posedge i_clk) begin
        if (w_start && i_queue.item.reads_table) begin
            r_rdata <= r_mem[w_raddr];
        end
        if (w_done && w_wr) begin
            r_mem[{~r_bank, r_item.target_row[SW-1:0]}] <= w_src_slot;
        end
    end

    // hold the started item
    always_ff @(posedge i_clk) begin
        if (w_start) r_item <= i_queue.item;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out_data <= {w_active_n, w_free_n, w_st,
                           (w_st == sarc_pkg::ST_OK) ? w_slot_out : SW'(0)};
        end
    end

    // control state, allocator state and free recount after a capacity write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cap       <= CW'(MS);
            r_map       <= '1;
            r_free_cnt  <= CW'(MS);
            r_active    <= '0;
            r_bank      <= 1'b0;
            r_ident     <= 2'b00;
            r_filled    <= '0;
            r_idx       <= '0;
            r_failed    <= 1'b0;
            r_recount   <= 1'b0;
            r_rc_idx    <= '0;
            r_rc_acc    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_done) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_start) r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (w_done) begin
                        r_state    <= S_IDLE;
                        r_map      <= w_map_n;
                        r_free_cnt <= w_free_n;
                        r_active   <= w_active_n;
                        r_bank     <= w_bank_n;
                        r_ident    <= w_ident_n;
                        r_filled   <= w_filled_n;
                        r_idx      <= w_idx_n;
                        r_failed   <= w_failed_n;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (i_cfg_we) begin
                r_cap     <= i_cfg_wdata;
                r_recount <= 1'b1;
                r_rc_idx  <= '0;
                r_rc_acc  <= '0;
            end else if (r_recount) begin
                if (r_rc_idx == CW'(MS)) begin
                    r_recount  <= 1'b0;
                    r_free_cnt <= r_rc_acc;
                end else begin
                    r_rc_idx <= r_rc_idx + CW'(1);
                    if (w_avail[r_rc_idx[SW-1:0]]) r_rc_acc <= r_rc_acc + CW'(1);
                end
            end
        end
    end

    a_free_le_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_recount && !$past(i_cfg_we)) |-> (r_free_cnt <= w_ecap))
        else $error("free count above capacity");
    a_active_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active <= CW'(MS))
        else $error("active rows above maximum");
    a_exec_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && !w_out_can) |=> (r_state == S_EXEC))
        else $error("item left execute without a result slot");
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> !o_pop)
        else $error("queue popped while executing");

endmodule

// ===== rtl/core/slot_allocator_with_row_compaction.sv =====
// ----------------------------------------------------------------------------
// slot_allocator_with_row_compaction
// Free-slot bitmap allocator with a two-bank row table and row compaction.
// ----------------------------------------------------------------------------
// The input transfer is written into the two-entry queue; the result is
// registered after the queue pop with table read and then the execute step.
// The back end takes no new item until it is through with the last one.
// After a capacity write the free count is recounted over all 64 slots, during
// which no item starts. Synchronous active-low reset frees all 64 slots,
// sets capacity 64, zeroes the active row count and clears queue and result.
module slot_allocator_with_row_compaction (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata,      // capacity
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [6:0] batch_size, [12:7] slot, [19:13] target_row, [26:20] new_batch_size,
    // [32:27] row
    input  logic [39:0] i_s_axis_tdata,
    input  logic        i_s_axis_tlast,   // last_row
    input  logic [2:0]  i_s_axis_tuser,   // [2:0] cmd
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [5:0] slot_out, [9:6] status, [16:10] free_count, [23:17] active_rows
    output logic [23:0] o_m_axis_tdata
);

    sarc_pkg::t_item      w_in_item;
    sarc_pkg::t_queue_out w_queue;
    logic                 w_pop;

    // unpack input transfer
    always_comb begin
        w_in_item.cmd            = i_s_axis_tuser;
        w_in_item.batch_size     = i_s_axis_tdata[6:0];
        w_in_item.slot           = i_s_axis_tdata[12:7];
        w_in_item.target_row     = i_s_axis_tdata[19:13];
        w_in_item.new_batch_size = i_s_axis_tdata[26:20];
        w_in_item.row            = i_s_axis_tdata[32:27];
        w_in_item.last_row       = i_s_axis_tlast;
        w_in_item.reads_table    = 1'b0;
    end

    sarc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_item  (w_in_item),
        .o_queue (w_queue),
        .i_pop   (w_pop)
    );

    sarc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_queue     (w_queue),
        .o_pop       (w_pop),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_data      (o_m_axis_tdata)
    );

endmodule

// ===== tb/sv/slot_allocator_with_row_compaction_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slot_allocator_with_row_compaction_checker
// Watches the command and result streams and the capacity port. Keeps its
// own copy of the free map, the two row table banks and the compaction state,
// works out the result of every accepted command and compares each result
// transfer, field by field, with the oldest one waiting.
// ----------------------------------------------------------------------------
module slot_allocator_with_row_compaction_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,
    input  logic        i_s_axis_tlast,
    input  logic [2:0]  i_s_axis_tuser,
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [23:0] i_m_axis_tdata,
    output int          o_pending,
    output int          o_active,
    output int          o_errors
);

    // lowest field in the lowest bits
    typedef struct packed {
        logic [6:0] active_rows;
        logic [6:0] free_count;
        logic [3:0] status;
        logic [5:0] slot_out;
    } t_alloc_result;

    logic [6:0]    capacity_q;
    logic [63:0]   free_bits;
    logic [5:0]    row_bank [2][sarc_pkg::MAX_SLOTS];
    logic          bank_sel;
    int            active_cnt;
    logic [63:0]   filled;
    int            map_idx;
    logic          compact_dead;
    t_alloc_result expected_q[$];
    t_alloc_result got, want;
    int            error_cnt;

    function automatic int eff_capacity();
        return (capacity_q > 7'd64) ? 64 : int'(capacity_q);
    endfunction

    function automatic int free_total();
        int n;
        n = 0;
        for (int i = 0; i < eff_capacity(); i++)
            if (free_bits[i]) n++;
        return n;
    endfunction

    function automatic logic [3:0] free_one(int s);
        if (s >= eff_capacity()) return sarc_pkg::ST_SLOT_RNG;
        if (free_bits[s]) return sarc_pkg::ST_DBL_FREE;
        free_bits[s] = 1'b1;
        return sarc_pkg::ST_OK;
    endfunction

    function automatic void clear_compaction();
        map_idx = 0;
        filled  = '0;
    endfunction

    // one compaction item: map or free the next old row
    function automatic logic [3:0] compact_step(logic [6:0] tgt, logic [6:0] nbs,
                                                logic last);
        logic [3:0] st;
        logic [5:0] s;
        st = sarc_pkg::ST_OK;
        if (compact_dead) begin
            if (last) begin
                compact_dead = 1'b0;
                clear_compaction();
            end
            return sarc_pkg::ST_OK;
        end
        if (int'(nbs) > active_cnt) st = sarc_pkg::ST_BATCH_RNG;
        else if (map_idx >= active_cnt) st = sarc_pkg::ST_SIZE_MIS;
        else begin
            s = row_bank[bank_sel][map_idx];
            if (tgt[6]) st = free_one(int'(s));
            else if (tgt >= nbs) st = sarc_pkg::ST_TGT_RNG;
            else if (filled[tgt[5:0]]) st = sarc_pkg::ST_DUP;
            else begin
                row_bank[!bank_sel][tgt[5:0]] = s;
                filled[tgt[5:0]] = 1'b1;
            end
            if (st == sarc_pkg::ST_OK) map_idx++;
        end
        if (st == sarc_pkg::ST_OK && last) begin
            if (map_idx != active_cnt) st = sarc_pkg::ST_SIZE_MIS;
            else begin
                for (int i = 0; i < int'(nbs); i++)
                    if (!filled[i]) begin
                        st = sarc_pkg::ST_HOLE;
                        break;
                    end
            end
            if (st == sarc_pkg::ST_OK) begin
                bank_sel   = !bank_sel;
                active_cnt = int'(nbs);
            end
            clear_compaction();
            return st;
        end
        if (st != sarc_pkg::ST_OK) begin
            clear_compaction();
            if (!last) compact_dead = 1'b1;
        end
        return st;
    endfunction

    // work out the result of one command transfer
    function automatic t_alloc_result allocate_step(logic [2:0] cmd, logic [39:0] d,
                                                    logic last);
        t_alloc_result r;
        logic [3:0]    st;
        logic [5:0]    so;
        int            cap;
        int            n;
        int            rw;
        st  = sarc_pkg::ST_OK;
        so  = '0;
        cap = eff_capacity();
        case (cmd)
            sarc_pkg::CMD_RESET_ALL: begin
                n = int'(d[6:0]);
                if (n > cap) st = sarc_pkg::ST_BATCH_RNG;
                else begin
                    free_bits = '0;
                    for (int i = 0; i < cap; i++) free_bits[i] = (i >= n);
                    for (int i = 0; i < n; i++) row_bank[bank_sel][i] = 6'(i);
                    active_cnt   = n;
                    compact_dead = 1'b0;
                    clear_compaction();
                end
            end
            sarc_pkg::CMD_RESERVE: begin
                st = sarc_pkg::ST_NONE_FREE;
                for (int i = 0; i < cap; i++)
                    if (free_bits[i]) begin
                        free_bits[i] = 1'b0;
                        so = 6'(i);
                        st = sarc_pkg::ST_OK;
                        break;
                    end
            end
            sarc_pkg::CMD_RELEASE: st = free_one(int'(d[12:7]));
            sarc_pkg::CMD_COMPACT: st = compact_step(d[19:13], d[26:20], last);
            sarc_pkg::CMD_READ_ROW: begin
                rw = int'(d[32:27]);
                if (rw >= active_cnt) st = sarc_pkg::ST_ROW_RNG;
                else so = row_bank[bank_sel][rw];
            end
            default: ;
        endcase
        r.slot_out    = (st == sarc_pkg::ST_OK) ? so : '0;
        r.status      = st;
        r.free_count  = 7'(free_total());
        r.active_rows = 7'(active_cnt);
        return r;
    endfunction

    task automatic report(input string what, input int got_v, input int want_v);
        $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got_v, want_v);
        error_cnt++;
    endtask

    // predict on command transfers, compare on result transfers
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            capacity_q   = 7'd64;
            free_bits    = '1;
            bank_sel     = 1'b0;
            active_cnt   = 0;
            compact_dead = 1'b0;
            clear_compaction();
            expected_q.delete();
            error_cnt    = 0;
        end else begin
            if (i_cfg_we) capacity_q = i_cfg_wdata;
            if (i_s_axis_tvalid && i_s_axis_tready)
                expected_q.insert(expected_q.size(),
                                  allocate_step(i_s_axis_tuser, i_s_axis_tdata,
                                                i_s_axis_tlast));
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got = i_m_axis_tdata;
                if (expected_q.size() == 0) begin
                    report("unexpected result", int'(got), 0);
                end else begin
                    want = expected_q.pop_front();
                    if (got.slot_out != want.slot_out)
                        report("slot_out", got.slot_out, want.slot_out);
                    if (got.status != want.status)
                        report("status", got.status, want.status);
                    if (got.free_count != want.free_count)
                        report("free_count", got.free_count, want.free_count);
                    if (got.active_rows != want.active_rows)
                        report("active_rows", got.active_rows, want.active_rows);
                end
            end
        end
        o_pending <= expected_q.size();
        o_active  <= active_cnt;
        o_errors  <= error_cnt;
    end

endmodule

// ===== tb/sv/slot_allocator_with_row_compaction_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slot_allocator_with_row_compaction_test
// Drives directed and random command streams into the slot allocator across
// several capacity settings, with random idle and stall bursts, one long
// result stall and drain pauses. The checker beside the block predicts and
// compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module slot_allocator_with_row_compaction_test;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [6:0]  i_cfg_wdata;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [39:0] i_s_axis_tdata;
    logic        i_s_axis_tlast;
    logic [2:0]  i_s_axis_tuser;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [23:0] o_m_axis_tdata;

    int pending, active_now, errors;
    int sent;
    int cap_set;
    bit quiet;
    bit long_hold;

    localparam logic [6:0] TGT_FREE = 7'h7F;

    slot_allocator_with_row_compaction u_top (.*);

    slot_allocator_with_row_compaction_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_m_axis_tdata  (o_m_axis_tdata),
        .o_pending       (pending),
        .o_active        (active_now),
        .o_errors        (errors)
    );

    always begin
        i_clk = 1'b0; #1;
        i_clk = 1'b1; #1;
    end

    initial begin
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // result side: random stall bursts, one long hold-off
    initial begin
        i_m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                i_m_axis_tready <= 1'b0;
                repeat (300) @(posedge i_clk);
                long_hold = 1'b0;
            end else if (quiet || $urandom_range(0, 3) != 0) begin
                i_m_axis_tready <= 1'b1;
            end else begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(0, 10)) @(posedge i_clk);
            end
        end
    end

    function automatic int eff_cap();
        return (cap_set > 64) ? 64 : cap_set;
    endfunction

    // one command transfer, with an optional idle burst in front
    task automatic send(input logic [2:0] c, input logic [6:0] bs, input logic [5:0] sl,
                        input logic [6:0] tg, input logic [6:0] nb, input logic lst,
                        input logic [5:0] rw);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= c;
        i_s_axis_tlast  <= lst;
        i_s_axis_tdata  <= {7'd0, rw, nb, tg, sl, bs};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sent++;
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_capacity(input int v);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= 7'(v);
        cap_set = v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // a whole compaction pass over the current rows, optionally broken
    task automatic compaction_pass(input bit broken);
        logic [6:0] tl[64];
        logic [6:0] tmp;
        logic [6:0] nbs;
        int n, k, j, stop;
        if (!quiet) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        n = active_now;
        k = $urandom_range(0, n);
        for (int i = 0; i < n; i++)
            tl[i] = (i < k) ? 7'(i) : {1'b1, 6'($urandom)};
        for (int i = n - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = tl[i]; tl[i] = tl[j]; tl[j] = tmp;
        end
        nbs  = 7'(k);
        stop = (n == 0) ? 0 : n - 1;
        if (broken) begin
            case ($urandom_range(0, 3))
                0: if (n > 0) tl[$urandom_range(0, n - 1)] = 7'($urandom);
                1: stop = $urandom_range(0, stop);
                2: nbs = 7'($urandom_range(0, 64));
                default: stop = stop + 1;
            endcase
        end
        for (int i = 0; i <= stop; i++)
            send(sarc_pkg::CMD_COMPACT, 7'($urandom), 6'($urandom),
                 (i < n) ? tl[i] : 7'($urandom), nbs, i == stop, 6'($urandom));
    endtask

    task automatic random_item();
        int p;
        p = $urandom_range(0, 99);
        if (p < 8)
            send(sarc_pkg::CMD_RESET_ALL, ($urandom_range(0, 9) == 0) ? 7'($urandom)
                 : 7'($urandom_range(0, eff_cap())), 6'($urandom), 7'($urandom),
                 7'($urandom), 1'($urandom), 6'($urandom));
        else if (p < 25)
            send(sarc_pkg::CMD_RESERVE, 7'($urandom), 6'($urandom), 7'($urandom),
                 7'($urandom), 1'($urandom), 6'($urandom));
        else if (p < 40)
            send(sarc_pkg::CMD_RELEASE, 7'($urandom), 6'($urandom), 7'($urandom),
                 7'($urandom), 1'($urandom), 6'($urandom));
        else if (p < 52)
            send(sarc_pkg::CMD_READ_ROW, 7'($urandom), 6'($urandom), 7'($urandom),
                 7'($urandom), 1'($urandom), 6'($urandom_range(0, active_now + 2)));
        else if (p < 55)
            send(3'($urandom_range(5, 7)), 7'($urandom), 6'($urandom), 7'($urandom),
                 7'($urandom), 1'($urandom), 6'($urandom));
        else if (p < 60)
            send(sarc_pkg::CMD_COMPACT, 7'($urandom), 6'($urandom), 7'($urandom),
                 7'($urandom), 1'($urandom), 6'($urandom));
        else
            compaction_pass($urandom_range(0, 4) == 0);
    endtask

    // stimulus and verdict
    initial begin
        int caps[6];
        caps = '{1, 127, 40, 64, 2, 0};
        sent = 0;
        quiet = 1'b0;
        long_hold = 1'b0;
        cap_set = 64;
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_wdata     <= 7'd0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tlast  <= 1'b0;
        i_s_axis_tuser  <= sarc_pkg::CMD_RESERVE;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, an unknown code, full map, double free
        send(sarc_pkg::CMD_READ_ROW, 7'd0, 6'd0, 7'd0, 7'd0, 1'b0, 6'd0);
        send(3'd7, 7'h7F, 6'h3F, 7'h7F, 7'h7F, 1'b1, 6'h3F);
        send(sarc_pkg::CMD_RESERVE, 7'd0, 6'd0, 7'd0, 7'd0, 1'b0, 6'd0);
        send(sarc_pkg::CMD_RESET_ALL, 7'd64, 6'd0, 7'd0, 7'd0, 1'b0, 6'd0);
        send(sarc_pkg::CMD_RESERVE, 7'd0, 6'd0, 7'd0, 7'd0, 1'b0, 6'd0);
        send(sarc_pkg::CMD_RELEASE, 7'd0, 6'd63, 7'd0, 7'd0, 1'b0, 6'd0);
        send(sarc_pkg::CMD_RELEASE, 7'd0, 6'd63, 7'd0, 7'd0, 1'b0, 6'd0);
        send(sarc_pkg::CMD_READ_ROW, 7'd0, 6'd0, 7'd0, 7'd0, 1'b0, 6'd63);
        // good compaction of four rows into three, then read back
        send(sarc_pkg::CMD_RESET_ALL, 7'd4, 6'd0, 7'd0, 7'd0, 1'b0, 6'd0);
        send(sarc_pkg::CMD_COMPACT, 7'd0, 6'd0, 7'd1, 7'd3, 1'b0, 6'd0);
        send(sarc_pkg::CMD_COMPACT, 7'd0, 6'd0, TGT_FREE, 7'd3, 1'b0, 6'd0);
        send(sarc_pkg::CMD_COMPACT, 7'd0, 6'd0, 7'd0, 7'd3, 1'b0, 6'd0);
        send(sarc_pkg::CMD_COMPACT, 7'd0, 6'd0, 7'd2, 7'd3, 1'b1, 6'd0);
        send(sarc_pkg::CMD_READ_ROW, 7'd0, 6'd0, 7'd0, 7'd0, 1'b0, 6'd0);
        send(sarc_pkg::CMD_READ_ROW, 7'd0, 6'd0, 7'd0, 7'd0, 1'b0, 6'd3);
        // size out of range, then discarded items until the last one
        send(sarc_pkg::CMD_COMPACT, 7'd0, 6'd0, 7'd0, 7'd4, 1'b0, 6'd0);
        send(sarc_pkg::CMD_COMPACT, 7'd0, 6'd0, 7'd0, 7'd3, 1'b1, 6'd0);
        // hole, duplicate, target range, too few, too many
        send(sarc_pkg::CMD_COMPACT, 7'd0, 6'd0, 7'd0, 7'd3, 1'b0, 6'd0);
        send(sarc_pkg::CMD_COMPACT, 7'd0, 6'd0, TGT_FREE, 7'd3, 1'b0, 6'd0);
        send(sarc_pkg::CMD_COMPACT, 7'd0, 6'd0, 7'd1, 7'd3, 1'b1, 6'd0);
        send(sarc_pkg::CMD_COMPACT, 7'd0, 6'd0, 7'd0, 7'd2, 1'b0, 6'd0);
        send(sarc_pkg::CMD_COMPACT, 7'd0, 6'd0, 7'd0, 7'd2, 1'b1, 6'd0);
        send(sarc_pkg::CMD_COMPACT, 7'd0, 6'd0, 7'd5, 7'd2, 1'b1, 6'd0);
        send(sarc_pkg::CMD_COMPACT, 7'd0, 6'd0, 7'd0, 7'd2, 1'b1, 6'd0);
        send(sarc_pkg::CMD_RESET_ALL, 7'd1, 6'd0, 7'd0, 7'd1, 1'b0, 6'd0);
        send(sarc_pkg::CMD_COMPACT, 7'd0, 6'd0, 7'd0, 7'd1, 1'b0, 6'd0);
        send(sarc_pkg::CMD_COMPACT, 7'd0, 6'd0, 7'd0, 7'd1, 1'b1, 6'd0);
        // capacity limits: range errors beyond a small capacity
        write_capacity(40);
        send(sarc_pkg::CMD_RELEASE, 7'd0, 6'd50, 7'd0, 7'd0, 1'b0, 6'd0);
        send(sarc_pkg::CMD_RESET_ALL, 7'd50, 6'd0, 7'd0, 7'd0, 1'b0, 6'd0);
        send(sarc_pkg::CMD_RESET_ALL, 7'd0, 6'd0, 7'd0, 7'd0, 1'b0, 6'd0);

        // random phases, each under its own capacity
        for (int ph = 0; sent < 1950; ph++) begin
            write_capacity(caps[ph % 6] == 0 ? $urandom_range(1, 127) : caps[ph % 6]);
            if (ph == 2) long_hold = 1'b1;
            send(sarc_pkg::CMD_RESET_ALL, 7'($urandom_range(0, eff_cap())), 6'd0, 7'd0,
                 7'd0, 1'b0, 6'd0);
            for (int i = 0; i < 150 && sent < 1950; i++) begin
                if (sent >= 1700) quiet = 1'b1;
                random_item();
            end
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
